// ===== rtl/ppsm_pkg.sv =====
package ppsm_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ScreenW   = 31;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned SumW      = 49;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned QueueDepthDefault = 2;

  // Register map, one 32-bit word each
  localparam logic [RegIdxW-1:0] REG_X_GAIN   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_X_OFFSET = 3'd1;
  localparam logic [RegIdxW-1:0] REG_Y_GAIN   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_Y_OFFSET = 3'd3;
  localparam logic [RegIdxW-1:0] REG_X_PPU    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_X_BIAS   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_Y_PPU    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_Y_BIAS   = 3'd7;

  localparam logic signed [DataW-1:0] ONE_Q16 = 32'sd65536;

  localparam logic signed [SumW-1:0] WORLD_MAX    = 49'sd2147483647;
  localparam logic signed [SumW-1:0] WORLD_MIN    = -49'sd2147483648;
  localparam logic signed [SumW-1:0] SCREEN_LIMIT = 49'sd655360000;

  typedef struct packed {
    logic signed [DataW-1:0] x_gain;
    logic signed [DataW-1:0] x_offset;
    logic signed [DataW-1:0] y_gain;
    logic signed [DataW-1:0] y_offset;
    logic signed [DataW-1:0] x_ppu;
    logic signed [DataW-1:0] x_bias;
    logic signed [DataW-1:0] y_ppu;
    logic signed [DataW-1:0] y_bias;
  } cfg_t;

  // World point handed from the front to the back
  typedef struct packed {
    logic signed [DataW-1:0] wx;
    logic signed [DataW-1:0] wy;
    logic                    first;
  } world_t;

  // Floor of a Q16.16 x Q16.16 product back to Q16.16, kept wide
  function automatic logic signed [SumW-1:0] q_shr(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> FracBits;
    return s[SumW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat_world(input logic signed [SumW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > WORLD_MAX) begin
      r = WORLD_MAX[DataW-1:0];
    end else if (v < WORLD_MIN) begin
      r = WORLD_MIN[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ScreenW-1:0] clamp_screen(input logic signed [SumW-1:0] v);
    logic signed [ScreenW-1:0] r;
    if (v > SCREEN_LIMIT) begin
      r = SCREEN_LIMIT[ScreenW-1:0];
    end else if (v < -SCREEN_LIMIT) begin
      r = ScreenW'(-SCREEN_LIMIT);
    end else begin
      r = v[ScreenW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ppsm_regs.sv =====
module ppsm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppsm_pkg::AddrW-1:0]    paddr,
  input  logic [ppsm_pkg::DataW-1:0]    pwdata,
  output logic [ppsm_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output ppsm_pkg::cfg_t                cfg_o
);

  ppsm_pkg::cfg_t                     cfg_q, cfg_d;
  logic [ppsm_pkg::RegIdxW-1:0]       idx;
  logic                               wr_en;

  assign idx    = paddr[ppsm_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ppsm_pkg::REG_X_GAIN:   cfg_d.x_gain   = pwdata;
        ppsm_pkg::REG_X_OFFSET: cfg_d.x_offset = pwdata;
        ppsm_pkg::REG_Y_GAIN:   cfg_d.y_gain   = pwdata;
        ppsm_pkg::REG_Y_OFFSET: cfg_d.y_offset = pwdata;
        ppsm_pkg::REG_X_PPU:    cfg_d.x_ppu    = pwdata;
        ppsm_pkg::REG_X_BIAS:   cfg_d.x_bias   = pwdata;
        ppsm_pkg::REG_Y_PPU:    cfg_d.y_ppu    = pwdata;
        ppsm_pkg::REG_Y_BIAS:   cfg_d.y_bias   = pwdata;
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppsm_pkg::REG_X_GAIN:   prdata = cfg_q.x_gain;
      ppsm_pkg::REG_X_OFFSET: prdata = cfg_q.x_offset;
      ppsm_pkg::REG_Y_GAIN:   prdata = cfg_q.y_gain;
      ppsm_pkg::REG_Y_OFFSET: prdata = cfg_q.y_offset;
      ppsm_pkg::REG_X_PPU:    prdata = cfg_q.x_ppu;
      ppsm_pkg::REG_X_BIAS:   prdata = cfg_q.x_bias;
      ppsm_pkg::REG_Y_PPU:    prdata = cfg_q.y_ppu;
      ppsm_pkg::REG_Y_BIAS:   prdata = cfg_q.y_bias;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_gain   <= ppsm_pkg::ONE_Q16;
      cfg_q.x_offset <= '0;
      cfg_q.y_gain   <= ppsm_pkg::ONE_Q16;
      cfg_q.y_offset <= '0;
      cfg_q.x_ppu    <= ppsm_pkg::ONE_Q16;
      cfg_q.x_bias   <= '0;
      cfg_q.y_ppu    <= ppsm_pkg::ONE_Q16;
      cfg_q.y_bias   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/ppsm_front.sv =====
module ppsm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ppsm_pkg::DataW-1:0] data_x_i,
  input  logic signed [ppsm_pkg::DataW-1:0] data_y_i,
  input  logic                              first_point_i,
  input  ppsm_pkg::cfg_t                    cfg_i,
  input  logic                              full_i,
  output logic                              push_o,
  output ppsm_pkg::world_t                  push_data_o
);

  logic                              prod_v_q, prod_v_d;
  logic signed [ppsm_pkg::ProdW-1:0] prod_x_q, prod_y_q;
  logic                              first_q;
  logic                              accept;

  assign push_o     = prod_v_q && !full_i;
  assign in_stall_o = prod_v_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    prod_v_d = prod_v_q;
    if (accept) begin
      prod_v_d = 1'b1;
    end else if (push_o) begin
      prod_v_d = 1'b0;
    end
  end

  // Floor-shift, add offset, saturate to 32 bits
  always_comb begin
    push_data_o.wx = ppsm_pkg::sat_world(ppsm_pkg::q_shr(prod_x_q)
                     + ppsm_pkg::SumW'(cfg_i.x_offset));
    push_data_o.wy = ppsm_pkg::sat_world(ppsm_pkg::q_shr(prod_y_q)
                     + ppsm_pkg::SumW'(cfg_i.y_offset));
    push_data_o.first = first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= prod_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_x_q <= ppsm_pkg::ProdW'(data_x_i) * ppsm_pkg::ProdW'(cfg_i.x_gain);
      prod_y_q <= ppsm_pkg::ProdW'(data_y_i) * ppsm_pkg::ProdW'(cfg_i.y_gain);
      first_q  <= first_point_i;
    end
  end

endmodule

// ===== rtl/ppsm_fifo.sv =====
module ppsm_fifo #(
  parameter int unsigned Depth = ppsm_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppsm_pkg::world_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ppsm_pkg::world_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ppsm_pkg::world_t  slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/ppsm_back.sv =====
module ppsm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ppsm_pkg::cfg_t                      cfg_i,
  input  logic                                valid_i,
  input  ppsm_pkg::world_t                    pop_data_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppsm_pkg::ScreenW-1:0] screen_x_o,
  output logic signed [ppsm_pkg::ScreenW-1:0] screen_y_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_x_min_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_x_max_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_y_min_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_y_max_o
);

  logic                                a_v_q, a_v_d, o_v_q, o_v_d;
  logic                                a_move;
  logic signed [ppsm_pkg::ProdW-1:0]   prod_x_q, prod_y_q;
  logic signed [ppsm_pkg::DataW-1:0]   min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [ppsm_pkg::DataW-1:0]   min_x_d, max_x_d, min_y_d, max_y_d;
  logic signed [ppsm_pkg::DataW-1:0]   wx, wy;

  assign wx     = pop_data_i.wx;
  assign wy     = pop_data_i.wy;
  assign a_move = a_v_q && (!o_v_q || !out_stall_i);
  assign pop_o  = valid_i && (!a_v_q || a_move);
  assign out_valid_o = o_v_q;

  always_comb begin
    a_v_d = a_v_q;
    o_v_d = o_v_q;
    if (pop_o) begin
      a_v_d = 1'b1;
    end else if (a_move) begin
      a_v_d = 1'b0;
    end
    if (a_move) begin
      o_v_d = 1'b1;
    end else if (!out_stall_i) begin
      o_v_d = 1'b0;
    end
  end

  // Extremes always reflect the item held in stage A
  always_comb begin
    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    if (pop_o) begin
      if (pop_data_i.first) begin
        min_x_d = wx;
        max_x_d = wx;
        min_y_d = wy;
        max_y_d = wy;
      end else begin
        if (wx < min_x_q) min_x_d = wx;
        if (wx > max_x_q) max_x_d = wx;
        if (wy < min_y_q) min_y_d = wy;
        if (wy > max_y_q) max_y_d = wy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
    end else begin
      a_v_q   <= a_v_d;
      o_v_q   <= o_v_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_x_q <= ppsm_pkg::ProdW'(wx) * ppsm_pkg::ProdW'(cfg_i.x_ppu);
      prod_y_q <= ppsm_pkg::ProdW'(wy) * ppsm_pkg::ProdW'(cfg_i.y_ppu);
    end
    if (a_move) begin
      screen_x_o    <= ppsm_pkg::clamp_screen(ppsm_pkg::q_shr(prod_x_q)
                       + ppsm_pkg::SumW'(cfg_i.x_bias));
      screen_y_o    <= ppsm_pkg::clamp_screen(ppsm_pkg::SumW'(cfg_i.y_bias)
                       - ppsm_pkg::q_shr(prod_y_q));
      world_x_min_o <= min_x_q;
      world_x_max_o <= max_x_q;
      world_y_min_o <= min_y_q;
      world_y_max_o <= max_y_q;
    end
  end

endmodule

// ===== rtl/plot_point_screen_mapper.sv =====
// Plot point screen mapper: maps one Q16.16 data point per item to world
// coordinates (gain and offset, saturated to 32 bits), tracks the running
// world minimum and maximum per axis, and maps to screen coordinates clamped
// to +/-10000 pixels.
// Input channel: in_valid_i / in_stall_o with data_x_i, data_y_i and
// first_point_i; first_point_i restarts the extreme tracking.
// Output channel: out_valid_o / out_stall_i with screen and world extremes.
// From the accepting edge an item passes the world product register, the
// queue, the screen product register and the output register. One item per
// cycle is sustained while the receiver does not stall.
// A QueueDepth-entry queue (two by default) sits between the world stage and
// the screen stage, so when the receiver stalls the output register holds,
// the queue fills and only then is in_stall_o raised.
// The user must write registers over APB only while idle; the block does not
// enforce this. pready is always high. Reset restores unity gains and pixel
// scales, zero offsets and biases, zero extremes, and empties the pipeline.
module plot_point_screen_mapper #(
  parameter int unsigned QueueDepth = ppsm_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppsm_pkg::AddrW-1:0]          paddr,
  input  logic [ppsm_pkg::DataW-1:0]          pwdata,
  output logic [ppsm_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ppsm_pkg::DataW-1:0]   data_x_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   data_y_i,
  input  logic                                first_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppsm_pkg::ScreenW-1:0] screen_x_o,
  output logic signed [ppsm_pkg::ScreenW-1:0] screen_y_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_x_min_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_x_max_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_y_min_o,
  output logic signed [ppsm_pkg::DataW-1:0]   world_y_max_o
);

  ppsm_pkg::cfg_t   cfg;
  ppsm_pkg::world_t push_data, pop_data;
  logic             push, full, pop, q_valid;

  ppsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_x_i      (data_x_i),
    .data_y_i      (data_y_i),
    .first_point_i (first_point_i),
    .cfg_i         (cfg),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ppsm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  ppsm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (q_valid),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .world_x_min_o (world_x_min_o),
    .world_x_max_o (world_x_max_o),
    .world_y_min_o (world_y_min_o),
    .world_y_max_o (world_y_max_o)
  );

endmodule

// ===== test/ppsm_point_checker.sv =====
module ppsm_point_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppsm_pkg::AddrW-1:0]          paddr,
  input  logic [ppsm_pkg::DataW-1:0]          pwdata,
  input  logic                                pready,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   data_x_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   data_y_i,
  input  logic                                first_point_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [ppsm_pkg::ScreenW-1:0] screen_x_i,
  input  logic signed [ppsm_pkg::ScreenW-1:0] screen_y_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   world_x_min_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   world_x_max_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   world_y_min_i,
  input  logic signed [ppsm_pkg::DataW-1:0]   world_y_max_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WorldHi     = 64'sd2147483647;
  localparam longint WorldLo     = -64'sd2147483648;
  localparam longint ScreenHi    = 64'sd655360000;
  localparam int     ReportLimit = 10;

  typedef struct packed {
    logic signed [ppsm_pkg::ScreenW-1:0] screen_x;
    logic signed [ppsm_pkg::ScreenW-1:0] screen_y;
    logic signed [ppsm_pkg::DataW-1:0]   x_min;
    logic signed [ppsm_pkg::DataW-1:0]   x_max;
    logic signed [ppsm_pkg::DataW-1:0]   y_min;
    logic signed [ppsm_pkg::DataW-1:0]   y_max;
  } mapped_point_t;

  ppsm_pkg::cfg_t                    settings;
  logic signed [ppsm_pkg::DataW-1:0] x_lo, x_hi, y_lo, y_hi;
  mapped_point_t                     awaited_points[$];
  mapped_point_t                     head;

  // Full 64-bit product, then floor back to Q16.16
  function automatic longint q16_product(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> ppsm_pkg::FracBits;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic map_point(input longint dx, input longint dy, input logic restart);
    longint        wx, wy, sx, sy;
    mapped_point_t p;
    wx = clip(q16_product(dx, longint'($signed(settings.x_gain)))
              + longint'($signed(settings.x_offset)), WorldLo, WorldHi);
    wy = clip(q16_product(dy, longint'($signed(settings.y_gain)))
              + longint'($signed(settings.y_offset)), WorldLo, WorldHi);
    if (restart) begin
      x_lo = wx[ppsm_pkg::DataW-1:0];
      x_hi = wx[ppsm_pkg::DataW-1:0];
      y_lo = wy[ppsm_pkg::DataW-1:0];
      y_hi = wy[ppsm_pkg::DataW-1:0];
    end else begin
      if (wx < longint'(x_lo)) x_lo = wx[ppsm_pkg::DataW-1:0];
      if (wx > longint'(x_hi)) x_hi = wx[ppsm_pkg::DataW-1:0];
      if (wy < longint'(y_lo)) y_lo = wy[ppsm_pkg::DataW-1:0];
      if (wy > longint'(y_hi)) y_hi = wy[ppsm_pkg::DataW-1:0];
    end
    sx = clip(q16_product(wx, longint'($signed(settings.x_ppu)))
              + longint'($signed(settings.x_bias)), -ScreenHi, ScreenHi);
    // screen y grows downwards
    sy = clip(longint'($signed(settings.y_bias))
              - q16_product(wy, longint'($signed(settings.y_ppu))), -ScreenHi, ScreenHi);
    p.screen_x = sx[ppsm_pkg::ScreenW-1:0];
    p.screen_y = sy[ppsm_pkg::ScreenW-1:0];
    p.x_min    = x_lo;
    p.x_max    = x_hi;
    p.y_min    = y_lo;
    p.y_max    = y_hi;
    awaited_points.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [ppsm_pkg::DataW-1:0] want,
                             input logic [ppsm_pkg::DataW-1:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= ReportLimit) begin
        $display("%0t: %s wrong on result %0d: expected %h, got %h",
                 $realtime, name, checked_o, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.x_gain   = ppsm_pkg::ONE_Q16;
      settings.x_offset = '0;
      settings.y_gain   = ppsm_pkg::ONE_Q16;
      settings.y_offset = '0;
      settings.x_ppu    = ppsm_pkg::ONE_Q16;
      settings.x_bias   = '0;
      settings.y_ppu    = ppsm_pkg::ONE_Q16;
      settings.y_bias   = '0;
      x_lo = '0;
      x_hi = '0;
      y_lo = '0;
      y_hi = '0;
      awaited_points.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ppsm_pkg::AddrW-1:2])
          ppsm_pkg::REG_X_GAIN:   settings.x_gain   = pwdata;
          ppsm_pkg::REG_X_OFFSET: settings.x_offset = pwdata;
          ppsm_pkg::REG_Y_GAIN:   settings.y_gain   = pwdata;
          ppsm_pkg::REG_Y_OFFSET: settings.y_offset = pwdata;
          ppsm_pkg::REG_X_PPU:    settings.x_ppu    = pwdata;
          ppsm_pkg::REG_X_BIAS:   settings.x_bias   = pwdata;
          ppsm_pkg::REG_Y_PPU:    settings.y_ppu    = pwdata;
          ppsm_pkg::REG_Y_BIAS:   settings.y_bias   = pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        map_point(data_x_i, data_y_i, first_point_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_points.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit) begin
            $display("%0t: result with no point outstanding: screen %h %h",
                     $realtime, screen_x_i, screen_y_i);
          end
        end else begin
          head = awaited_points.pop_front();
          check_field("screen_x", 32'(head.screen_x), 32'(screen_x_i));
          check_field("screen_y", 32'(head.screen_y), 32'(screen_y_i));
          check_field("world_x_min", head.x_min, world_x_min_i);
          check_field("world_x_max", head.x_max, world_x_max_i);
          check_field("world_y_min", head.y_min, world_y_min_i);
          check_field("world_y_max", head.y_max, world_y_max_i);
          checked_o++;
        end
      end
      pending_o = awaited_points.size();
    end
  end

endmodule

// ===== test/tb_plot_point_screen_mapper.sv =====
module tb_plot_point_screen_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int ResetCycles = 11;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 40;
  localparam int PointsPerSet = 130;
  localparam int SetsPerPhase = 5;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                psel, penable, pwrite, pready;
  logic [ppsm_pkg::AddrW-1:0]          paddr;
  logic [ppsm_pkg::DataW-1:0]          pwdata, prdata;
  logic                                in_valid_i, in_stall_o;
  logic signed [ppsm_pkg::DataW-1:0]   data_x_i, data_y_i;
  logic                                first_point_i;
  logic                                out_valid_o, out_stall_i;
  logic signed [ppsm_pkg::ScreenW-1:0] screen_x_o, screen_y_o;
  logic signed [ppsm_pkg::DataW-1:0]   world_x_min_o, world_x_max_o;
  logic signed [ppsm_pkg::DataW-1:0]   world_y_min_o, world_y_max_o;

  int fail_count, pending, checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings_loaded = 0;
  int stall_cycles = 0;
  int holds_asked = 0;
  int holds_done = 0;

  plot_point_screen_mapper uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_x_i      (data_x_i),
    .data_y_i      (data_y_i),
    .first_point_i (first_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .world_x_min_o (world_x_min_o),
    .world_x_max_o (world_x_max_o),
    .world_y_min_o (world_y_min_o),
    .world_y_max_o (world_y_max_o)
  );

  ppsm_point_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_x_i      (data_x_i),
    .data_y_i      (data_y_i),
    .first_point_i (first_point_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_x_i    (screen_x_o),
    .screen_y_i    (screen_y_o),
    .world_x_min_i (world_x_min_o),
    .world_x_max_i (world_x_max_o),
    .world_y_min_i (world_y_min_o),
    .world_y_max_i (world_y_max_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) stall_cycles++;
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int k;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_asked) begin
        out_stall_i <= 1'b1;
        for (k = 1; k < HoldCycles; k++) @(posedge clk_i);
        holds_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [ppsm_pkg::DataW-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return int'($urandom_range(0, 512)) - 256;
      default: return int'($urandom_range(0, 33554432)) - 16777216;
    endcase
  endfunction

  function automatic logic [ppsm_pkg::DataW-1:0] pick_reg(input int unsigned span);
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return ppsm_pkg::ONE_Q16;
      default: return int'($urandom_range(0, 2 * span)) - int'(span);
    endcase
  endfunction

  function automatic ppsm_pkg::cfg_t make_settings(
    input logic [ppsm_pkg::DataW-1:0] xg, xo, yg, yo, xp, xb, yp, yb);
    ppsm_pkg::cfg_t c;
    c.x_gain   = xg;
    c.x_offset = xo;
    c.y_gain   = yg;
    c.y_offset = yo;
    c.x_ppu    = xp;
    c.x_bias   = xb;
    c.y_ppu    = yp;
    c.y_bias   = yb;
    return c;
  endfunction

  function automatic ppsm_pkg::cfg_t random_settings();
    return make_settings(pick_reg(1 << 19), pick_reg(1 << 25), pick_reg(1 << 19),
                         pick_reg(1 << 25), pick_reg(1 << 20), pick_reg(1 << 29),
                         pick_reg(1 << 20), pick_reg(1 << 29));
  endfunction

  // Leaves psel and penable high; load_settings drops them after the last write
  task automatic apb_write(input logic [ppsm_pkg::RegIdxW-1:0] idx,
                           input logic [ppsm_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic load_settings(input ppsm_pkg::cfg_t c);
    apb_write(ppsm_pkg::REG_X_GAIN,   c.x_gain);
    apb_write(ppsm_pkg::REG_X_OFFSET, c.x_offset);
    apb_write(ppsm_pkg::REG_Y_GAIN,   c.y_gain);
    apb_write(ppsm_pkg::REG_Y_OFFSET, c.y_offset);
    apb_write(ppsm_pkg::REG_X_PPU,    c.x_ppu);
    apb_write(ppsm_pkg::REG_X_BIAS,   c.x_bias);
    apb_write(ppsm_pkg::REG_Y_PPU,    c.y_ppu);
    apb_write(ppsm_pkg::REG_Y_BIAS,   c.y_bias);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // Drop valid, let the last item reach the checker, then wait until every
  // point has come back out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_point(input logic [ppsm_pkg::DataW-1:0] x,
                            input logic [ppsm_pkg::DataW-1:0] y,
                            input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_x_i      <= x;
    data_y_i      <= y;
    first_point_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : stimulus
    int phase, blk, n;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    data_x_i      = '0;
    data_y_i      = '0;
    first_point_i = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings; the first two points track against the zero extremes
    send_point(32'h0064_0000, 32'hFFCE_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0001, 1'b0);
    drain();

    // Extreme gains and offsets: world saturation both ways
    load_settings(make_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                ppsm_pkg::ONE_Q16, '0, ppsm_pkg::ONE_Q16, '0));
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 1'b0);
    drain();

    // Extreme pixel scales and biases: screen clamp
    load_settings(make_settings(ppsm_pkg::ONE_Q16, '0, ppsm_pkg::ONE_Q16, '0,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_1234, 32'hFFFF_EDCC, 1'b0);
    send_point(32'h0003_0000, 32'hFFFD_0000, 1'b0);
    drain();

    // A plausible plot window
    load_settings(make_settings(32'h0002_8000, 32'hFFFD_0000, 32'hFFFF_8000, 32'h0007_4000,
                                32'h000A_0000, 32'h0032_0000, 32'h0008_0000, 32'h0258_0000));
    send_point(32'h0001_0000, 32'h0002_0000, 1'b1);
    send_point(32'hFFFE_8000, 32'h0010_0000, 1'b0);
    send_point(32'h0020_0000, 32'hFFF0_0000, 1'b0);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0005_5555, 32'h0003_3333, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (blk = 0; blk < SetsPerPhase; blk++) begin
        drain();
        if (phase == 1 && blk == 0) begin
          load_settings(make_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h8000_0000, 32'h7FFF_FFFF));
        end else begin
          load_settings(random_settings());
        end
        for (n = 0; n < PointsPerSet; n++) begin
          // long receiver hold-off while the sender keeps offering items
          if (blk == 2 && n == 60 && phase != 1) holds_asked++;
          send_point(pick_sample(), pick_sample(), n == 0 || $urandom_range(24) == 0);
        end
      end
    end
    drain();

    $display("Mapped %0d points through %0d register settings and three traffic mixes,",
             checked, settings_loaded);
    $display("with %0d cycles of input back-pressure.", stall_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppsm_pkg.sv
rtl/ppsm_regs.sv
rtl/ppsm_front.sv
rtl/ppsm_fifo.sv
rtl/ppsm_back.sv
rtl/plot_point_screen_mapper.sv
test/ppsm_point_checker.sv
test/tb_plot_point_screen_mapper.sv
